>>> sv/tks_pkg.sv
package tks_pkg;

    localparam int VAL_W = 31;
    localparam int SUM_W = 39;
    localparam int KC_W  = 9;

    localparam logic [KC_W-1:0] KEEP_COUNT_RESET = KC_W'(1);

    typedef struct packed {
        logic idle;
        logic done;
    } tks_stat_t;

endpackage

>>> sv/tks_if.sv
interface tks_sample_if import tks_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface tks_sum_if import tks_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] top_sum;

    modport source (output valid, output top_sum, input ready);
    modport sink   (input valid, input top_sum, output ready);
endinterface

interface tks_cfg_if import tks_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [KC_W-1:0] keep_count;

    modport source (output valid, output keep_count, input ready);
    modport sink   (input valid, input keep_count, output ready);
endinterface

>>> sv/tks_ram.sv
module tks_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

>>> sv/tks_heap_seq.sv
module tks_heap_seq import tks_pkg::*; #(
    parameter int HEAP_DEPTH = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [VAL_W-1:0]              sample_value,
    input  logic [$clog2(HEAP_DEPTH):0]   k_eff,
    input  logic                          take,
    output tks_stat_t                     stat,
    output logic [SUM_W-1:0]              sum
);

    localparam int AW  = $clog2(HEAP_DEPTH);
    localparam int FW  = AW + 1;
    localparam int CIW = AW + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UP   = 3'd1;
    localparam logic [2:0] S_PUT  = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_DOWN = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [VAL_W-1:0] v_reg, v_next;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic [AW-1:0]    ra_a, ra_b;
    logic [VAL_W-1:0] rd_a, rd_b;

    logic             ins;
    logic [AW-1:0]    up_idx;
    logic [CIW-1:0]   l_idx, r_idx, nl_idx, nr_idx;
    logic             l_ok, r_ok, pick_l, pick_r;
    logic [VAL_W-1:0] cur_min;
    logic [AW-1:0]    best;

    tks_ram #(
        .WIDTH (VAL_W),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (ra_a),
        .rd_data_a (rd_a),
        .rd_addr_b (ra_b),
        .rd_data_b (rd_b)
    );

    assign ins    = fill_reg < k_eff;
    assign up_idx = (pos_reg - AW'(1)) >> 1;

    // children of the current hole and of the chosen child
    assign l_idx  = {1'b0, pos_reg, 1'b1};
    assign r_idx  = l_idx + CIW'(1);
    assign l_ok   = l_idx < {1'b0, fill_reg};
    assign r_ok   = r_idx < {1'b0, fill_reg};
    assign pick_l = l_ok && (rd_a < v_reg);
    assign cur_min = pick_l ? rd_a : v_reg;
    assign pick_r = r_ok && (rd_b < cur_min);
    assign best   = pick_r ? r_idx[AW-1:0] : l_idx[AW-1:0];
    assign nl_idx = {1'b0, best, 1'b1};
    assign nr_idx = nl_idx + CIW'(1);

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        fill_next  = fill_reg;
        sum_next   = sum_reg;
        v_next     = v_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = v_reg;
        ra_a       = '0;
        ra_b       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    v_next = sample_value;
                    if (ins)
                    begin
                        fill_next = fill_reg + FW'(1);
                        sum_next  = sum_reg + {{(SUM_W-VAL_W){1'b0}}, sample_value};
                        pos_next  = fill_reg[AW-1:0];
                        ra_a      = (fill_reg[AW-1:0] - AW'(1)) >> 1;
                        state_next = (fill_reg == '0) ? S_PUT : S_UP;
                    end
                    else
                    begin
                        ra_a       = '0;
                        state_next = S_ROOT;
                    end
                end
            end
            S_UP:
            begin
                wr_en = 1'b1;
                if (rd_a <= v_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    // move the parent down into the hole
                    wr_data  = rd_a;
                    pos_next = up_idx;
                    ra_a     = (up_idx - AW'(1)) >> 1;
                    if (up_idx == '0)
                    begin
                        state_next = S_PUT;
                    end
                end
            end
            S_PUT:
            begin
                wr_en      = 1'b1;
                state_next = S_FIN;
            end
            S_ROOT:
            begin
                if (v_reg >= rd_a)
                begin
                    sum_next = sum_reg - {{(SUM_W-VAL_W){1'b0}}, rd_a}
                                       + {{(SUM_W-VAL_W){1'b0}}, v_reg};
                    pos_next   = '0;
                    ra_a       = AW'(1);
                    ra_b       = AW'(2);
                    state_next = S_DOWN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DOWN:
            begin
                wr_en = 1'b1;
                if (pick_l || pick_r)
                begin
                    // move the smaller child up into the hole
                    wr_data  = pick_r ? rd_b : rd_a;
                    pos_next = best;
                    ra_a     = nl_idx[AW-1:0];
                    ra_b     = nr_idx[AW-1:0];
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_FIN);
    assign sum       = sum_reg;

    a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start && ins) |=> fill_reg == $past(fill_reg) + FW'(1))
        else $error("heap fill did not advance on insert");

    a_down_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DOWN) |-> ({1'b0, pos_reg} < fill_reg))
        else $error("sift-down hole outside the heap");

    a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP) |-> (pos_reg != '0))
        else $error("sift-up step at the root");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(HEAP_DEPTH))
        else $error("heap fill beyond depth");

endmodule

>>> sv/top_k_running_sum.sv
// Sample transfer to result valid: heap walk states, S_FIN, then the output register;
// one heap level per cycle in the sift-up or sift-down walk on the heap memory.
// A new sample is accepted only while the sequencer is idle; a finished result holds it in
// S_FIN while the output register has not drained.
// A new sample is taken while the previous result still waits in the output register.
// Reset (rst_n, async, active low): heap empty, sum zero, keep_count 1; memory not cleared.
module top_k_running_sum import tks_pkg::*; #(
    parameter int HEAP_DEPTH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    tks_cfg_if.sink        cfg,
    tks_sample_if.sink     sample,
    tks_sum_if.source      result
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = (AW + 1 > KC_W) ? AW + 1 : KC_W;

    logic [KC_W-1:0]  kc_reg;
    logic [CW-1:0]    kc_ext, k_min1, k_sat;
    logic [AW:0]      k_eff;
    logic             out_valid_reg;
    logic [SUM_W-1:0] top_sum_reg;
    logic [SUM_W-1:0] seq_sum;
    logic             take, start;
    tks_stat_t        stat;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kc_reg <= KEEP_COUNT_RESET;
        end
        else if (cfg.valid)
        begin
            kc_reg <= cfg.keep_count;
        end
    end

    // clamp K into 1..HEAP_DEPTH
    assign kc_ext = CW'(kc_reg);
    assign k_min1 = (kc_ext == '0) ? CW'(1) : kc_ext;
    assign k_sat  = (k_min1 > CW'(HEAP_DEPTH)) ? CW'(HEAP_DEPTH) : k_min1;
    assign k_eff  = k_sat[AW:0];

    assign sample.ready = stat.idle;
    assign start        = sample.valid && stat.idle;
    assign take         = !out_valid_reg || result.ready;

    tks_heap_seq #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .sample_value (sample.sample_value),
        .k_eff        (k_eff),
        .take         (take),
        .stat         (stat),
        .sum          (seq_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.done && take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done && take)
        begin
            top_sum_reg <= seq_sum;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.top_sum = top_sum_reg;

endmodule
